### hw/rtl/cpid_pkg.sv
// cpid_pkg: widths, register indexes, reset values and sequencer states of the cascaded pid
package cpid_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 32;
  localparam int FRAC_W    = 24;
  localparam int LIMIT_W   = 15;
  localparam int ERR_W     = SAMPLE_W + 1;
  localparam int DELTA_W   = ERR_W + 1;
  localparam int PROD_W    = DELTA_W + GAIN_W;
  localparam int INTEG_W   = 41;
  localparam int ISUM_W    = PROD_W + 1;
  localparam int ACC_W     = PROD_W + 2;
  localparam int CFG_IDX_W = 3;
  localparam int DRIVE_W   = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic        [LIMIT_W-1:0]  limit_t;
  typedef logic signed [ERR_W-1:0]    err_t;
  typedef logic signed [DELTA_W-1:0]  delta_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [INTEG_W-1:0]  integ_t;
  typedef logic signed [ISUM_W-1:0]   isum_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [DRIVE_W-1:0]  drive_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_KP   = 3'd0,
    REG_SPEED_KI   = 3'd1,
    REG_SPEED_KD   = 3'd2,
    REG_ANGLE_KP   = 3'd3,
    REG_ANGLE_KI   = 3'd4,
    REG_ANGLE_KD   = 3'd5,
    REG_INTEG_LIM  = 3'd6,
    REG_OUTPUT_LIM = 3'd7
  } cfg_reg_t;

  localparam gain_t  SPEED_KP_RST   = 32'sd134218;
  localparam gain_t  SPEED_KI_RST   = 32'sd1678;
  localparam gain_t  SPEED_KD_RST   = 32'sd0;
  localparam gain_t  ANGLE_KP_RST   = 32'sd671088640;
  localparam gain_t  ANGLE_KI_RST   = 32'sd0;
  localparam gain_t  ANGLE_KD_RST   = 32'sd8388608;
  localparam limit_t INTEG_LIM_RST  = 15'd10000;
  localparam limit_t OUTPUT_LIM_RST = 15'd10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_I,
    ST_MUL_P,
    ST_MUL_D,
    ST_SUM
  } seq_state_t;

endpackage

### hw/rtl/cpid_in_if.sv
// cpid_in_if: request channel carrying one control tick
interface cpid_in_if;
  logic             valid;
  logic             ready;
  logic             action;
  cpid_pkg::sample_t target;
  cpid_pkg::sample_t measured_angle;
  cpid_pkg::sample_t measured_speed;

  modport source (output valid, output action, output target, output measured_angle,
                  output measured_speed, input ready);
  modport sink (input valid, input action, input target, input measured_angle,
                input measured_speed, output ready);
endinterface

### hw/rtl/cpid_out_if.sv
// cpid_out_if: result channel carrying the motor drive value
interface cpid_out_if;
  logic             valid;
  logic             ready;
  cpid_pkg::drive_t drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

### hw/rtl/cascaded_pid_controller.sv
// cascaded_pid_controller: speed or angle-then-speed positional pid on one shared multiplier
//
//  channel  | direction | handshake          | payload
//  in_ch    | in        | valid/ready        | action, target, measured_angle, measured_speed
//  out_ch   | out       | valid/ready        | drive
//  cfg_*    | in        | cfg_we, no ready   | cfg_index, cfg_wdata
//
// cascade runs the angle loop before the speed loop; both share the single 18x32 multiplier
// each loop runs err, three multiplies (ki, kp, kd) and a final sum-clamp-truncate step
// in_ch.ready is high only in idle; a held result sits in the output register meanwhile
// if out_ch stalls, the last sum step waits until the output register is free
// rst_n is synchronous: gains and limits take their reset values, loop state clears
module cascaded_pid_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  cpid_in_if.sink                           in_ch,
  cpid_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpid_pkg::GAIN_W-1:0]       cfg_wdata
);

  cpid_pkg::seq_state_t state_r, state_nxt;

  cpid_pkg::gain_t  speed_kp_r, speed_ki_r, speed_kd_r;
  cpid_pkg::gain_t  angle_kp_r, angle_ki_r, angle_kd_r;
  cpid_pkg::limit_t integ_lim_r, output_lim_r;

  cpid_pkg::err_t   spd_prev_r, ang_prev_r;
  cpid_pkg::integ_t spd_integ_r, ang_integ_r;

  logic              angle_r;
  cpid_pkg::sample_t ref_r, fb_r, m_speed_r;
  cpid_pkg::err_t    err_r;
  cpid_pkg::delta_t  delta_r;
  cpid_pkg::prod_t   prod_r;
  cpid_pkg::acc_t    acc_r;

  logic              out_valid_r;
  cpid_pkg::drive_t  drive_r;

  logic              in_acc;
  logic              out_free;
  logic              load_out;

  cpid_pkg::err_t    err_c, prev_sel;
  cpid_pkg::integ_t  integ_sel;
  cpid_pkg::gain_t   kp_sel, ki_sel, kd_sel;
  cpid_pkg::delta_t  mul_a;
  cpid_pkg::gain_t   mul_b;
  cpid_pkg::prod_t   mul_p;
  cpid_pkg::isum_t   isum, ilim_fx, integ_clamp;
  cpid_pkg::acc_t    tot, olim_fx, tot_clamp, tot_mag;
  logic [cpid_pkg::LIMIT_W-1:0] res_mag;
  cpid_pkg::drive_t  res;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == cpid_pkg::ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = drive_r;

  // per-loop operand selection
  assign prev_sel  = angle_r ? ang_prev_r  : spd_prev_r;
  assign integ_sel = angle_r ? ang_integ_r : spd_integ_r;
  assign kp_sel    = angle_r ? angle_kp_r  : speed_kp_r;
  assign ki_sel    = angle_r ? angle_ki_r  : speed_ki_r;
  assign kd_sel    = angle_r ? angle_kd_r  : speed_kd_r;

  assign err_c = cpid_pkg::err_t'(ref_r) - cpid_pkg::err_t'(fb_r);

  // shared multiplier
  always_comb begin
    mul_a = cpid_pkg::delta_t'(err_r);
    mul_b = ki_sel;
    case (state_r)
      cpid_pkg::ST_MUL_P: begin
        mul_b = kp_sel;
      end
      cpid_pkg::ST_MUL_D: begin
        mul_a = delta_r;
        mul_b = kd_sel;
      end
      default: begin
        mul_b = ki_sel;
      end
    endcase
  end

  assign mul_p = cpid_pkg::prod_t'(mul_a) * cpid_pkg::prod_t'(mul_b);

  // integral update with anti-windup clamp
  assign ilim_fx = cpid_pkg::isum_t'({integ_lim_r, {cpid_pkg::FRAC_W{1'b0}}});
  assign isum    = cpid_pkg::isum_t'(integ_sel) + cpid_pkg::isum_t'(prod_r);

  always_comb begin
    if (isum > ilim_fx) begin
      integ_clamp = ilim_fx;
    end else if (isum < -ilim_fx) begin
      integ_clamp = -ilim_fx;
    end else begin
      integ_clamp = isum;
    end
  end

  // output sum, clamp and truncation toward zero
  assign olim_fx = cpid_pkg::acc_t'({output_lim_r, {cpid_pkg::FRAC_W{1'b0}}});
  assign tot     = acc_r + cpid_pkg::acc_t'(prod_r);

  always_comb begin
    if (tot > olim_fx) begin
      tot_clamp = olim_fx;
    end else if (tot < -olim_fx) begin
      tot_clamp = -olim_fx;
    end else begin
      tot_clamp = tot;
    end
    tot_mag = tot_clamp[cpid_pkg::ACC_W-1] ? -tot_clamp : tot_clamp;
    res_mag = tot_mag[cpid_pkg::FRAC_W +: cpid_pkg::LIMIT_W];
    res     = tot_clamp[cpid_pkg::ACC_W-1] ? -cpid_pkg::drive_t'({1'b0, res_mag})
                                           :  cpid_pkg::drive_t'({1'b0, res_mag});
  end

  assign load_out = (state_r == cpid_pkg::ST_SUM) && !angle_r && out_free;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpid_pkg::ST_IDLE:  if (in_acc) state_nxt = cpid_pkg::ST_ERR;
      cpid_pkg::ST_ERR:   state_nxt = cpid_pkg::ST_MUL_I;
      cpid_pkg::ST_MUL_I: state_nxt = cpid_pkg::ST_MUL_P;
      cpid_pkg::ST_MUL_P: state_nxt = cpid_pkg::ST_MUL_D;
      cpid_pkg::ST_MUL_D: state_nxt = cpid_pkg::ST_SUM;
      cpid_pkg::ST_SUM: begin
        if (angle_r) begin
          state_nxt = cpid_pkg::ST_ERR;
        end else if (out_free) begin
          state_nxt = cpid_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cpid_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpid_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_kp_r   <= cpid_pkg::SPEED_KP_RST;
      speed_ki_r   <= cpid_pkg::SPEED_KI_RST;
      speed_kd_r   <= cpid_pkg::SPEED_KD_RST;
      angle_kp_r   <= cpid_pkg::ANGLE_KP_RST;
      angle_ki_r   <= cpid_pkg::ANGLE_KI_RST;
      angle_kd_r   <= cpid_pkg::ANGLE_KD_RST;
      integ_lim_r  <= cpid_pkg::INTEG_LIM_RST;
      output_lim_r <= cpid_pkg::OUTPUT_LIM_RST;
    end else if (cfg_we) begin
      unique case (cpid_pkg::cfg_reg_t'(cfg_index))
        cpid_pkg::REG_SPEED_KP:   speed_kp_r   <= cfg_wdata;
        cpid_pkg::REG_SPEED_KI:   speed_ki_r   <= cfg_wdata;
        cpid_pkg::REG_SPEED_KD:   speed_kd_r   <= cfg_wdata;
        cpid_pkg::REG_ANGLE_KP:   angle_kp_r   <= cfg_wdata;
        cpid_pkg::REG_ANGLE_KI:   angle_ki_r   <= cfg_wdata;
        cpid_pkg::REG_ANGLE_KD:   angle_kd_r   <= cfg_wdata;
        cpid_pkg::REG_INTEG_LIM:  integ_lim_r  <= cfg_wdata[cpid_pkg::LIMIT_W-1:0];
        cpid_pkg::REG_OUTPUT_LIM: output_lim_r <= cfg_wdata[cpid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_prev_r  <= '0;
      ang_prev_r  <= '0;
      spd_integ_r <= '0;
      ang_integ_r <= '0;
      angle_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        angle_r <= in_ch.action;
      end else if (state_r == cpid_pkg::ST_SUM && angle_r) begin
        angle_r <= 1'b0;
      end
      if (state_r == cpid_pkg::ST_ERR) begin
        if (angle_r) ang_prev_r <= err_c;
        else         spd_prev_r <= err_c;
      end
      if (state_r == cpid_pkg::ST_MUL_P) begin
        if (angle_r) ang_integ_r <= cpid_pkg::integ_t'(integ_clamp);
        else         spd_integ_r <= cpid_pkg::integ_t'(integ_clamp);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ref_r     <= in_ch.target;
      fb_r      <= in_ch.action ? in_ch.measured_angle : in_ch.measured_speed;
      m_speed_r <= in_ch.measured_speed;
    end else if (state_r == cpid_pkg::ST_SUM && angle_r) begin
      // angle result becomes the speed target
      ref_r <= res;
      fb_r  <= m_speed_r;
    end
    if (state_r == cpid_pkg::ST_ERR) begin
      err_r   <= err_c;
      delta_r <= cpid_pkg::delta_t'(err_c) - cpid_pkg::delta_t'(prev_sel);
    end
    if (state_r == cpid_pkg::ST_MUL_I || state_r == cpid_pkg::ST_MUL_P
        || state_r == cpid_pkg::ST_MUL_D) begin
      prod_r <= mul_p;
    end
    if (state_r == cpid_pkg::ST_MUL_D) begin
      // p term plus the freshly clamped integral
      acc_r <= cpid_pkg::acc_t'(prod_r) + cpid_pkg::acc_t'(integ_sel);
    end
    if (load_out) begin
      drive_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

### hw/rtl/cpid_checker.sv
// cpid_checker: port-level assertions for the cascaded pid, bound to the top level
module cpid_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [cpid_pkg::DRIVE_W-1:0] out_drive
);

  // a request keeps the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted request");

  // no result rises while the request's first loop is in its err, ki and kp steps
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too soon after a request");

  // the clamp keeps drive off the most negative code
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive != {1'b1, {(cpid_pkg::DRIVE_W-1){1'b0}}})
    else $error("drive outside the clamp range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive))
    else $error("stalled result dropped or changed");

endmodule

bind cascaded_pid_controller cpid_checker u_cpid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_drive (out_ch.drive)
);

### tb/tb.sv
// tb: self-checking testbench for the cascaded pid controller with a built-in drive predictor
module tb;

  localparam bit ACT_SPEED   = 1'b0;
  localparam bit ACT_CASCADE = 1'b1;
  localparam int LOOP_SPEED  = 0;
  localparam int LOOP_ANGLE  = 1;
  localparam int N_REGS      = 8;
  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 80;
  localparam int MAX_IDLE    = 8;
  localparam int TAIL_CYCLES = 16;
  localparam int RUN_LIMIT   = 3000000;

  typedef struct {
    bit                          is_write;
    cpid_pkg::cfg_reg_t          index;
    logic [cpid_pkg::GAIN_W-1:0] wdata;
    logic                        action;
    cpid_pkg::sample_t           target;
    cpid_pkg::sample_t           measured_angle;
    cpid_pkg::sample_t           measured_speed;
    bit                          has_drive;
    cpid_pkg::drive_t            drive;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [cpid_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cpid_pkg::GAIN_W-1:0] cfg_wdata;

  cpid_in_if  in_ch ();
  cpid_out_if out_ch ();

  cascaded_pid_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers and of both loops' state
  logic [cpid_pkg::GAIN_W-1:0] reg_rst [N_REGS];
  logic [cpid_pkg::GAIN_W-1:0] reg_copy [N_REGS];
  longint loop_prev_err [2];
  longint loop_integ [2];

  cpid_pkg::drive_t drive_expected_q [$];
  stim_row_t stim_table [$];
  int mismatch_count = 0;
  bit idle_on = 1'b1;

  function automatic longint clamp_sym(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint pid_update(int loop, longint setpoint, longint feedback);
    cpid_pkg::gain_t kp, ki, kd;
    longint ilim, olim, e, d_part;
    if (loop == LOOP_ANGLE) begin
      kp = reg_copy[cpid_pkg::REG_ANGLE_KP];
      ki = reg_copy[cpid_pkg::REG_ANGLE_KI];
      kd = reg_copy[cpid_pkg::REG_ANGLE_KD];
    end else begin
      kp = reg_copy[cpid_pkg::REG_SPEED_KP];
      ki = reg_copy[cpid_pkg::REG_SPEED_KI];
      kd = reg_copy[cpid_pkg::REG_SPEED_KD];
    end
    ilim = longint'(reg_copy[cpid_pkg::REG_INTEG_LIM]) <<< cpid_pkg::FRAC_W;
    olim = longint'(reg_copy[cpid_pkg::REG_OUTPUT_LIM]) <<< cpid_pkg::FRAC_W;
    e = setpoint - feedback;
    d_part = (e - loop_prev_err[loop]) * kd;
    loop_prev_err[loop] = e;
    loop_integ[loop] = clamp_sym(loop_integ[loop] + e * ki, ilim);
    // signed division drops the fraction toward zero
    return clamp_sym(e * kp + d_part + loop_integ[loop], olim)
           / (longint'(1) <<< cpid_pkg::FRAC_W);
  endfunction

  function automatic cpid_pkg::drive_t predict_drive(stim_row_t row);
    longint speed_set;
    speed_set = longint'(row.target);
    if (row.action == ACT_CASCADE)
      speed_set = pid_update(LOOP_ANGLE, longint'(row.target), longint'(row.measured_angle));
    return cpid_pkg::drive_t'(pid_update(LOOP_SPEED, speed_set,
                                         longint'(row.measured_speed)));
  endfunction

  function automatic int draw_idle();
    return idle_on ? $urandom_range(0, MAX_IDLE) : 0;
  endfunction

  function automatic cpid_pkg::sample_t rand_sample();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1, 2:    return cpid_pkg::sample_t'($urandom);
      default: return cpid_pkg::sample_t'($urandom_range(0, 2000)) - 16'sd1000;
    endcase
  endfunction

  function automatic logic [cpid_pkg::GAIN_W-1:0] rand_gain(
      logic [cpid_pkg::GAIN_W-1:0] rst_val);
    int unsigned mag;
    int k;
    case ($urandom_range(0, 9))
      0:       return rst_val;
      1:       return '0;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4, 5:    return $urandom;
      default: begin
        k = $urandom_range(12, 27);
        mag = $urandom_range(0, (1 << k) - 1);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic logic [cpid_pkg::GAIN_W-1:0] rand_limit(
      logic [cpid_pkg::GAIN_W-1:0] rst_val);
    logic [cpid_pkg::GAIN_W-1:0] data;
    // junk in the upper bits must be masked off by the block
    data = $urandom;
    case ($urandom_range(0, 5))
      0:       data[cpid_pkg::LIMIT_W-1:0] = '0;
      1:       data[cpid_pkg::LIMIT_W-1:0] = '1;
      2:       data[cpid_pkg::LIMIT_W-1:0] = rst_val[cpid_pkg::LIMIT_W-1:0];
      default: data[cpid_pkg::LIMIT_W-1:0] = cpid_pkg::limit_t'($urandom_range(0, 32767));
    endcase
    return data;
  endfunction

  function automatic void add_tick(logic action, cpid_pkg::sample_t tgt,
                                   cpid_pkg::sample_t ang, cpid_pkg::sample_t spd,
                                   bit has_drive, cpid_pkg::drive_t drive);
    stim_row_t row;
    row = '{is_write: 1'b0, index: cpid_pkg::REG_SPEED_KP, wdata: '0, action: action,
            target: tgt, measured_angle: ang, measured_speed: spd, has_drive: has_drive,
            drive: drive};
    stim_table.push_back(row);
  endfunction

  function automatic void add_write(cpid_pkg::cfg_reg_t index,
                                    logic [cpid_pkg::GAIN_W-1:0] wdata);
    stim_row_t row;
    row = '{is_write: 1'b1, index: index, wdata: wdata, action: ACT_SPEED, target: '0,
            measured_angle: '0, measured_speed: '0, has_drive: 1'b0, drive: '0};
    stim_table.push_back(row);
  endfunction

  // caller lowers cfg_we once the batch of writes is done
  task automatic cfg_write(cpid_pkg::cfg_reg_t index, logic [cpid_pkg::GAIN_W-1:0] wdata);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= wdata;
    @(posedge clk);
    if (index == cpid_pkg::REG_INTEG_LIM || index == cpid_pkg::REG_OUTPUT_LIM)
      reg_copy[index] = {{(cpid_pkg::GAIN_W-cpid_pkg::LIMIT_W){1'b0}},
                         wdata[cpid_pkg::LIMIT_W-1:0]};
    else
      reg_copy[index] = wdata;
  endtask

  task automatic send_tick(stim_row_t row, int gap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= row.action;
    in_ch.target         <= row.target;
    in_ch.measured_angle <= row.measured_angle;
    in_ch.measured_speed <= row.measured_speed;
    do @(posedge clk); while (!in_ch.ready);
    // predictor always runs so its state follows the block
    if (row.has_drive) begin
      void'(predict_drive(row));
      drive_expected_q.push_back(row.drive);
    end else begin
      drive_expected_q.push_back(predict_drive(row));
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (drive_expected_q.size() != 0) @(posedge clk);
  endtask

  // result side: random back-pressure, in-order check
  initial begin
    int stall;
    cpid_pkg::drive_t expected;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_idle();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (drive_expected_q.size() == 0) begin
        $display("%0t: drive %0d with no request pending", $time, out_ch.drive);
        mismatch_count++;
      end else begin
        expected = drive_expected_q.pop_front();
        if (out_ch.drive !== expected) begin
          $display("%0t: drive mismatch, expected %0d, got %0d", $time, expected, out_ch.drive);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #RUN_LIMIT;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    stim_row_t row;
    int pressure_at;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= ACT_SPEED;
    in_ch.target         <= '0;
    in_ch.measured_angle <= '0;
    in_ch.measured_speed <= '0;

    reg_rst[cpid_pkg::REG_SPEED_KP]   = cpid_pkg::SPEED_KP_RST;
    reg_rst[cpid_pkg::REG_SPEED_KI]   = cpid_pkg::SPEED_KI_RST;
    reg_rst[cpid_pkg::REG_SPEED_KD]   = cpid_pkg::SPEED_KD_RST;
    reg_rst[cpid_pkg::REG_ANGLE_KP]   = cpid_pkg::ANGLE_KP_RST;
    reg_rst[cpid_pkg::REG_ANGLE_KI]   = cpid_pkg::ANGLE_KI_RST;
    reg_rst[cpid_pkg::REG_ANGLE_KD]   = cpid_pkg::ANGLE_KD_RST;
    reg_rst[cpid_pkg::REG_INTEG_LIM]  = {{(cpid_pkg::GAIN_W-cpid_pkg::LIMIT_W){1'b0}},
                                         cpid_pkg::INTEG_LIM_RST};
    reg_rst[cpid_pkg::REG_OUTPUT_LIM] = {{(cpid_pkg::GAIN_W-cpid_pkg::LIMIT_W){1'b0}},
                                         cpid_pkg::OUTPUT_LIM_RST};
    reg_copy = reg_rst;
    loop_prev_err = '{0, 0};
    loop_integ    = '{0, 0};

    // reset gains: full-scale speed error gives 530, then -524 once the integral cancels
    add_tick(ACT_SPEED,   16'sd0,      16'sd0,      16'sd0,      1'b1, 16'sd0);
    add_tick(ACT_SPEED,   16'sh7FFF,   16'sh7FFF,   16'sh8000,   1'b1, 16'sd530);
    add_tick(ACT_SPEED,   16'sh8000,   16'sh8000,   16'sh7FFF,   1'b1, -16'sd524);
    add_tick(ACT_CASCADE, 16'sh7FFF,   16'sh8000,   16'sd0,      1'b0, '0);
    add_tick(ACT_CASCADE, 16'sh8000,   16'sh7FFF,   16'sh8000,   1'b0, '0);
    add_tick(ACT_CASCADE, 16'sd0,      16'sd0,      16'sd0,      1'b0, '0);
    // speed-only tick leaves the angle loop untouched
    add_tick(ACT_SPEED,   16'sd100,    16'sh5A5A,   -16'sd100,   1'b0, '0);
    add_tick(ACT_CASCADE, 16'sd5,      16'sd3,      16'sd7,      1'b0, '0);
    // zero output limit forces the drive to zero
    add_write(cpid_pkg::REG_OUTPUT_LIM, 32'h0000_0000);
    add_tick(ACT_CASCADE, 16'sh7FFF,   16'sh8000,   16'sh8000,   1'b1, 16'sd0);
    add_tick(ACT_SPEED,   16'sh8000,   16'sd0,      16'sh7FFF,   1'b1, 16'sd0);
    // zero integral limit, output limit of 5 hidden under junk upper bits
    add_write(cpid_pkg::REG_INTEG_LIM, 32'hFFFF_0000);
    add_write(cpid_pkg::REG_OUTPUT_LIM, 32'hFFFF_8005);
    add_tick(ACT_SPEED,   16'sh7FFF,   16'sd0,      16'sh8000,   1'b1, 16'sd5);
    add_tick(ACT_SPEED,   16'sh8000,   16'sd0,      16'sh7FFF,   1'b1, -16'sd5);
    // gain and limit extremes
    add_write(cpid_pkg::REG_SPEED_KP, 32'h7FFF_FFFF);
    add_write(cpid_pkg::REG_SPEED_KI, 32'h8000_0000);
    add_write(cpid_pkg::REG_SPEED_KD, 32'h8000_0000);
    add_write(cpid_pkg::REG_ANGLE_KP, 32'h8000_0000);
    add_write(cpid_pkg::REG_ANGLE_KI, 32'h7FFF_FFFF);
    add_write(cpid_pkg::REG_ANGLE_KD, 32'h7FFF_FFFF);
    add_write(cpid_pkg::REG_INTEG_LIM, 32'h0000_7FFF);
    add_write(cpid_pkg::REG_OUTPUT_LIM, 32'hFFFF_FFFF);
    add_tick(ACT_SPEED,   16'sh7FFF,   16'sd0,      16'sh8000,   1'b0, '0);
    add_tick(ACT_CASCADE, 16'sh8000,   16'sh7FFF,   16'sh7FFF,   1'b0, '0);
    add_tick(ACT_CASCADE, 16'sh7FFF,   16'sh8000,   16'sh8000,   1'b0, '0);
    add_tick(ACT_SPEED,   16'sd0,      16'sd0,      16'sd0,      1'b0, '0);
    add_tick(ACT_CASCADE, 16'sd1,      16'sd0,      16'sd0,      1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < stim_table.size(); i++) begin
      row = stim_table[i];
      if (row.is_write) begin
        drain_results();
        cfg_write(row.index, row.wdata);
        if (i + 1 == stim_table.size() || !stim_table[i + 1].is_write)
          cfg_we <= 1'b0;
      end else begin
        send_tick(row, draw_idle());
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      for (int r = 0; r < N_REGS; r++) begin
        // first phase runs on the reset tuning to reach steady control behaviour
        if (phase == 0)
          cfg_write(cpid_pkg::cfg_reg_t'(r), reg_rst[r]);
        else if (r == cpid_pkg::REG_INTEG_LIM || r == cpid_pkg::REG_OUTPUT_LIM)
          cfg_write(cpid_pkg::cfg_reg_t'(r), rand_limit(reg_rst[r]));
        else
          cfg_write(cpid_pkg::cfg_reg_t'(r), rand_gain(reg_rst[r]));
      end
      cfg_we <= 1'b0;
      idle_on = (phase % 4) != 3;
      pressure_at = $urandom_range(10, PHASE_TICKS - 10);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        row.is_write       = 1'b0;
        row.has_drive      = 1'b0;
        row.action         = $urandom_range(0, 1) ? ACT_CASCADE : ACT_SPEED;
        row.target         = rand_sample();
        row.measured_angle = rand_sample();
        row.measured_speed = rand_sample();
        send_tick(row, draw_idle());
        // hold off until every pending request has been answered
        if (n == pressure_at)
          drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
